// ===== src/assert_macros.svh =====
// Assertion macros shared by the grid mesh index generator RTL.
// Used by the top level; has no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define GMIG_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("gmig assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define GMIG_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   `GMIG_ASSERT(lbl, clk, rst, (ante) |-> (cons))

`endif

// ===== src/gmig_pkg.sv =====
// Package for the grid mesh index generator: types, register codes and helpers.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package gmig_pkg;

   localparam int MAX_GRID_DIM = 256;
   localparam int DIM_W        = $clog2(MAX_GRID_DIM) + 1;
   localparam int CNT_W        = $clog2(MAX_GRID_DIM);
   localparam int IDX_W        = 16;

   localparam logic [DIM_W-1:0] DIM_MIN       = DIM_W'(2);
   localparam logic [DIM_W-1:0] DIM_MAX       = DIM_W'(MAX_GRID_DIM);
   localparam logic [DIM_W-1:0] DIM_RESET     = DIM_W'(100);
   localparam logic             MODE_RESET    = 1'b1;

   typedef enum logic [1:0] {
      CSR_MODE      = 2'd0,
      CSR_GRID_COLS = 2'd1,
      CSR_GRID_ROWS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_HORIZ = 2'd0,
      PH_VERT  = 2'd1,
      PH_BAND  = 2'd2,
      PH_DEGEN = 2'd3
   } phase_type;

   typedef struct packed {
      logic             mode;
      logic [DIM_W-1:0] cols;
      logic [DIM_W-1:0] rows;
   } gmig_cfg_type;

   typedef struct packed {
      logic valid;
      logic mode;
   } gmig_restart_type;

   typedef struct packed {
      phase_type        phase;
      logic [CNT_W-1:0] row_count;
      logic [CNT_W-1:0] col_count;
      logic [CNT_W-1:0] degen_count;
      logic             second_of_pair;
      logic [IDX_W-1:0] row_base;
   } gmig_state_type;

   function automatic logic [DIM_W-1:0] gmig_clamp(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v < DIM_MIN) begin
         r = DIM_MIN;
      end else if (v > DIM_MAX) begin
         r = DIM_MAX;
      end
      return r;
   endfunction

   function automatic gmig_state_type gmig_init(input logic mode);
      gmig_state_type s;
      s.phase          = mode ? PH_BAND : PH_HORIZ;
      s.row_count      = '0;
      s.col_count      = '0;
      s.degen_count    = '0;
      s.second_of_pair = 1'b0;
      s.row_base       = '0;
      return s;
   endfunction

endpackage

// ===== src/gmig_csr.sv =====
// Configuration registers of the grid mesh index generator with dimension clamping.
// Depends on gmig_pkg.
`timescale 1ns / 1ps

module gmig_csr
   import gmig_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [DIM_W-1:0] csr_data,
   output gmig_cfg_type     cfg,
   output gmig_restart_type restart
);

   gmig_cfg_type cfg_ff;
   gmig_cfg_type cfg_in;
   logic         hit;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      hit    = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            CSR_MODE: begin
               cfg_in.mode = csr_data[0];
               hit         = 1'b1;
            end
            CSR_GRID_COLS: begin
               cfg_in.cols = gmig_clamp(csr_data);
               hit         = 1'b1;
            end
            CSR_GRID_ROWS: begin
               cfg_in.rows = gmig_clamp(csr_data);
               hit         = 1'b1;
            end
            default: begin
               hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= MODE_RESET;
         cfg_ff.cols <= DIM_RESET;
         cfg_ff.rows <= DIM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg           = cfg_ff;
   assign restart.valid = hit;
   assign restart.mode  = cfg_in.mode;

endmodule

// ===== src/gmig_step.sv =====
// Next-state and index logic of the grid mesh index generator for one word.
// Depends on gmig_pkg.
`timescale 1ns / 1ps

module gmig_step
   import gmig_pkg::*;
(
   input  gmig_cfg_type     cfg,
   input  gmig_state_type   state,
   input  logic             restart,
   output gmig_state_type   state_next,
   output logic [IDX_W-1:0] vertex_index,
   output logic             last
);

   gmig_state_type   s;
   gmig_state_type   n;
   logic [DIM_W-1:0] cols_m1;
   logic [DIM_W-1:0] rows_m1;
   logic [DIM_W-1:0] rows_m2;
   logic [DIM_W-1:0] col_inc;
   logic [CNT_W-1:0] degen_dec;
   logic [IDX_W-1:0] cols_ext;
   logic [IDX_W-1:0] top_off;
   logic [IDX_W-1:0] idx;
   logic             fin;

   always_comb begin
      s         = restart ? gmig_init(cfg.mode) : state;
      n         = s;
      fin       = 1'b0;
      cols_m1   = cfg.cols - DIM_W'(1);
      rows_m1   = cfg.rows - DIM_W'(1);
      rows_m2   = cfg.rows - DIM_W'(2);
      col_inc   = {1'b0, s.col_count} + DIM_W'(1);
      degen_dec = (s.degen_count != '0) ? s.degen_count - CNT_W'(1) : '0;
      cols_ext  = IDX_W'(cfg.cols);
      top_off   = s.second_of_pair ? cols_ext : '0;
      idx       = '0;
      case (s.phase)
         PH_HORIZ: begin
            idx = s.row_base + IDX_W'(s.col_count) + IDX_W'(s.second_of_pair);
            if (s.second_of_pair) begin
               n.second_of_pair = 1'b0;
               n.col_count      = col_inc[CNT_W-1:0];
               if (col_inc >= cols_m1) begin
                  n.col_count = '0;
                  if ({1'b0, s.row_count} >= rows_m1) begin
                     n.phase     = PH_VERT;
                     n.row_count = '0;
                     n.row_base  = '0;
                  end else begin
                     n.row_count = s.row_count + CNT_W'(1);
                     n.row_base  = s.row_base + cols_ext;
                  end
               end
            end else begin
               n.second_of_pair = 1'b1;
            end
         end
         PH_VERT: begin
            idx = s.row_base + IDX_W'(s.col_count) + top_off;
            if (s.second_of_pair) begin
               n.second_of_pair = 1'b0;
               if ({1'b0, s.row_count} >= rows_m2) begin
                  n.row_count = '0;
                  n.row_base  = '0;
                  if ({1'b0, s.col_count} >= cols_m1) begin
                     fin = 1'b1;
                  end else begin
                     n.col_count = s.col_count + CNT_W'(1);
                  end
               end else begin
                  n.row_count = s.row_count + CNT_W'(1);
                  n.row_base  = s.row_base + cols_ext;
               end
            end else begin
               n.second_of_pair = 1'b1;
            end
         end
         PH_BAND: begin
            idx = s.row_base + IDX_W'(s.col_count) + top_off;
            if (s.second_of_pair) begin
               n.second_of_pair = 1'b0;
               n.col_count      = col_inc[CNT_W-1:0];
               if (col_inc >= cfg.cols) begin
                  n.col_count = '0;
                  if ({1'b0, s.row_count} >= rows_m2) begin
                     fin = 1'b1;
                  end else begin
                     n.row_count   = s.row_count + CNT_W'(1);
                     n.row_base    = s.row_base + cols_ext;
                     n.phase       = PH_DEGEN;
                     n.degen_count = cols_m1[CNT_W-1:0];
                  end
               end
            end else begin
               n.second_of_pair = 1'b1;
            end
         end
         PH_DEGEN: begin
            idx = s.row_base + IDX_W'(s.degen_count);
            if ({1'b0, s.degen_count} >= cols_m1 || s.second_of_pair ||
                s.degen_count == '0) begin
               n.second_of_pair = 1'b0;
               n.degen_count    = degen_dec;
               if (degen_dec == '0) begin
                  n.phase     = PH_BAND;
                  n.col_count = '0;
               end
            end else begin
               n.second_of_pair = 1'b1;
            end
         end
         default: begin
            n = s;
         end
      endcase
      if (fin) begin
         n = gmig_init(cfg.mode);
      end
   end

   assign state_next   = n;
   assign vertex_index = idx;
   assign last         = fin;

endmodule

// ===== src/grid_mesh_index_generator_core.sv =====
// Grid mesh index generator, top level: sequence state, result register, config.
// The result of an accepted word is registered and shown in the cycle after; throughput one word per cycle.
// The input stalls only while a result waits under an output stall; otherwise a word goes in
// every cycle, also in the cycle its predecessor's result is taken.
// Synchronous active-high reset restores mode 1 and a 100 by 100 grid at the first index.
// Depends on gmig_pkg, gmig_csr, gmig_step and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grid_mesh_index_generator_core
   import gmig_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_restart,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [IDX_W-1:0] rsp_vertex_index,
   output logic             rsp_last,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [DIM_W-1:0] csr_data
);

   gmig_cfg_type     cfg;
   gmig_restart_type cfg_restart;
   gmig_state_type   state_ff;
   gmig_state_type   state_in;
   gmig_state_type   step_next;
   logic [IDX_W-1:0] step_index;
   logic             step_last;
   logic             req_accept;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [IDX_W-1:0] rsp_index_ff;
   logic [IDX_W-1:0] rsp_index_in;
   logic             rsp_last_ff;
   logic             rsp_last_in;
   logic             strip_phase;
   logic [IDX_W-1:0] row_base_want;
   logic             counts_ok;
   logic [IDX_W-1:0] last_index_want;

   gmig_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .restart   (cfg_restart)
   );

   gmig_step u_step (
      .cfg          (cfg),
      .state        (state_ff),
      .restart      (req_restart),
      .state_next   (step_next),
      .vertex_index (step_index),
      .last         (step_last)
   );

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      if (cfg_restart.valid) begin
         state_in = gmig_init(cfg_restart.mode);
      end else if (req_accept) begin
         state_in = step_next;
      end
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = step_index;
         rsp_last_in  = step_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gmig_init(MODE_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_index_ff;
   assign rsp_last         = rsp_last_ff;

   assign strip_phase     = (state_ff.phase == PH_BAND) || (state_ff.phase == PH_DEGEN);
   assign row_base_want   = IDX_W'({8'd0, state_ff.row_count} * {7'd0, cfg.cols});
   assign counts_ok       = ({1'b0, state_ff.col_count} < cfg.cols) &&
                            ({1'b0, state_ff.degen_count} < cfg.cols);
   assign last_index_want = IDX_W'({8'd0, cfg.rows} * {8'd0, cfg.cols} - 18'd1);

   `GMIG_ASSERT(a_phase_mode, clock, reset, cfg.mode == strip_phase)
   `GMIG_ASSERT(a_row_base, clock, reset, state_ff.row_base == row_base_want)
   `GMIG_ASSERT(a_counts, clock, reset, counts_ok)
   `GMIG_ASSERT_IMPL(a_last_index, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_index_ff == last_index_want)

endmodule
